// File: hdl/soft_shape_alpha_generator_top_defines.svh
// Assertion macros for the sprite alpha generator
`ifndef SOFT_SHAPE_ALPHA_GENERATOR_TOP_DEFINES_SVH
`define SOFT_SHAPE_ALPHA_GENERATOR_TOP_DEFINES_SVH
// assert that antecedent implies consequent in the same cycle
`define SSAG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// assert that antecedent implies consequent in the next cycle
`define SSAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: hdl/ssag_pkg.sv
// Package: shared constants and shape codes for the sprite alpha generator
`default_nettype none
package ssag_pkg;
	localparam int SPRITE_SIZE = 64;
	localparam int FRAC_BITS = 9;
	localparam int COORD_W = 6;
	localparam int ALPHA_W = 8;
	localparam int SHAPE_W = 3;
	localparam int HALF_W = 7;
	localparam int SQ_W = 14;
	localparam logic [SHAPE_W-1:0] SHAPE_DISK = 3'd0;
	localparam logic [SHAPE_W-1:0] SHAPE_SQUARE = 3'd1;
	localparam logic [SHAPE_W-1:0] SHAPE_LINE = 3'd2;
	localparam logic [SHAPE_W-1:0] SHAPE_CIRCLE = 3'd3;
	localparam logic [SHAPE_W-1:0] SHAPE_RING = 3'd4;
	localparam logic [SHAPE_W-1:0] SHAPE_SPHERE = 3'd5;
	localparam logic [0:0] REG_SHAPE = 1'b0;
endpackage
`default_nettype wire

// File: hdl/ssag_if.sv
// Interfaces: valid/ready stream channels for pixels and alphas
`default_nettype none
interface ssag_pix_if;
	logic valid;
	logic ready;
	logic [ssag_pkg::COORD_W-1:0] pixel_col;
	logic [ssag_pkg::COORD_W-1:0] pixel_row;
	modport source (output valid, pixel_col, pixel_row, input ready);
	modport sink (input valid, pixel_col, pixel_row, output ready);
endinterface

interface ssag_alpha_if;
	logic valid;
	logic ready;
	logic [ssag_pkg::ALPHA_W-1:0] alpha;
	modport source (output valid, alpha, input ready);
	modport sink (input valid, alpha, output ready);
endinterface
`default_nettype wire

// File: hdl/soft_shape_alpha_generator_top.sv
// Top level: sprite alpha generator with APB shape register
//  channel | dir | handshake    | payload
//  pix     | in  | valid/ready  | pixel_col, pixel_row
//  alp     | out | valid/ready  | alpha
//  apb     | in  | psel/penable | shape_select at 0x0
// One pixel per cycle unless stalled; the path is 2 front stages, FRAC_BITS+HALF_W root
// cells, 2 shading stages and an output register.
// The whole chain advances together; it stalls only while the output register
// is full and not taken. arst_n clears valid bits and shape_select.
`default_nettype none
module soft_shape_alpha_generator_top #(
	parameter int FRAC_BITS = ssag_pkg::FRAC_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ssag_pix_if.sink         pix,
	ssag_alpha_if.source     alp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	localparam int D_W = ssag_pkg::HALF_W + FRAC_BITS;      // root width
	localparam int RW = 2 * D_W;
	localparam int NC = RW / 2;
	localparam int LAT = 2 + NC + 2;
	localparam int SW = ssag_pkg::SQ_W;
	localparam int TW = 2 + 7 + ssag_pkg::SHAPE_W;          // flags, larger offset, shape
	localparam logic [D_W-1:0] R26 = D_W'(26 << FRAC_BITS);
	localparam logic [D_W-1:0] R6 = D_W'(6 << FRAC_BITS);
	localparam logic [D_W-1:0] R27 = D_W'(27 << FRAC_BITS);
	localparam logic [D_W-1:0] R29 = D_W'(29 << FRAC_BITS);
	localparam logic [D_W-1:0] R32 = D_W'(32 << FRAC_BITS);
	localparam logic [D_W-1:0] SPAN25 = D_W'((5 << FRAC_BITS) / 2);
	localparam logic [D_W-1:0] SPAN6 = D_W'(6 << FRAC_BITS);
	localparam logic [15:0] DIV3_M = 16'd21846;
	localparam logic [15:0] DIV5_M = 16'd13108;
	localparam logic [12:0] DIV25_M = 13'd5243;

	logic [ssag_pkg::SHAPE_W-1:0] shape_q;
	logic [LAT-1:0] vld_q;
	logic [ssag_pkg::ALPHA_W-1:0] out_q;
	logic out_vld_q;
	logic adv;

	assign pready = 1'b1;
	assign prdata = {29'd0, shape_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q <= ssag_pkg::SHAPE_DISK;
		end else if (psel && penable && pwrite && paddr == {1'b0, ssag_pkg::REG_SHAPE}) begin
			shape_q <= pwdata[ssag_pkg::SHAPE_W-1:0];
		end
	end

	assign adv = !out_vld_q || alp.ready;
	assign pix.ready = adv;

	// front stage 1: half-unit offsets
	logic [6:0] ax_s1, ay_s1;
	logic [ssag_pkg::SHAPE_W-1:0] sh_s1;
	logic [7:0] tx, ty;
	always_comb begin
		tx = {1'b0, pix.pixel_col, 1'b0} - 8'd61;
		ty = {1'b0, pix.pixel_row, 1'b0} - 8'd61;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1 <= tx[7] ? 7'(-tx) : tx[6:0];
			ay_s1 <= ty[7] ? 7'(-ty) : ty[6:0];
			sh_s1 <= shape_q;
		end
	end

	// front stage 2: root operand; line uses its own corner distance
	logic [RW-1:0] sq_s2;
	logic [TW-1:0] tag_s2;
	logic [8:0] my_c, m_c, xr_c, yr_c;
	logic [SW-1:0] sum_c;
	always_comb begin
		my_c = 9'(ay_s1) * 9'd6;
		m_c = ({2'd0, ax_s1} > my_c) ? {2'd0, ax_s1} : my_c;
		xr_c = ({2'd0, ax_s1} > 9'd44) ? {2'd0, ax_s1} - 9'd44 : 9'd0;
		yr_c = (my_c > 9'd44) ? my_c - 9'd44 : 9'd0;
		if (sh_s1 == ssag_pkg::SHAPE_LINE)
			sum_c = SW'(xr_c) * SW'(xr_c) + SW'(yr_c) * SW'(yr_c);
		else
			sum_c = SW'(ax_s1) * SW'(ax_s1) + SW'(ay_s1) * SW'(ay_s1);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s2 <= RW'(sum_c) << (2 * FRAC_BITS - 2);
			tag_s2 <= {(m_c < 9'd44), (m_c > 9'd56),
				(ax_s1 > ay_s1) ? ax_s1 : ay_s1, sh_s1};
		end
	end

	logic [RW-1:0] root_w;
	logic [TW-1:0] tag_w;
	ssag_sqrt_chain #(.RW(RW), .TW(TW)) u_chain (
		.clk(clk), .en(adv), .val_i(sq_s2), .tag_i(tag_s2),
		.root_o(root_w), .tag_o(tag_w)
	);

	// shade stage 1: numerators
	logic [D_W-1:0] d_c, mx_c, diff_c;
	logic [ssag_pkg::SHAPE_W-1:0] sh_c;
	logic [D_W+8:0] num_s3;
	logic [2*D_W-1:0] e2_s3;
	logic [2:0] mode_s3;
	logic sat_s3;
	localparam logic [2:0] M_ZERO = 3'd0, M_EDGE = 3'd1, M_OUT = 3'd2, M_RING = 3'd3,
		M_LINE = 3'd4, M_SPH = 3'd5;
	always_comb begin
		d_c = root_w[D_W-1:0];
		sh_c = tag_w[ssag_pkg::SHAPE_W-1:0];
		mx_c = D_W'(tag_w[ssag_pkg::SHAPE_W +: 7]) << (FRAC_BITS - 1);
		diff_c = (d_c >= R26) ? d_c - R26 : R26 - d_c;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			num_s3 <= '0;
			e2_s3 <= '0;
			sat_s3 <= 1'b0;
			mode_s3 <= M_ZERO;
			case (sh_c)
				ssag_pkg::SHAPE_DISK, ssag_pkg::SHAPE_SQUARE: begin
					if (((sh_c == ssag_pkg::SHAPE_DISK) ? d_c : mx_c) < R27) begin
						sat_s3 <= 1'b1;
					end else if (((sh_c == ssag_pkg::SHAPE_DISK) ? d_c : mx_c) <= R29) begin
						mode_s3 <= M_EDGE;
						num_s3 <= (D_W+9)'(255) *
							(D_W+9)'(R29 - ((sh_c == ssag_pkg::SHAPE_DISK) ? d_c : mx_c));
					end
				end
				ssag_pkg::SHAPE_LINE: begin
					if (tag_w[TW-1]) sat_s3 <= 1'b1;
					else if (!tag_w[TW-2] && d_c <= SPAN6) begin
						mode_s3 <= M_LINE;
						num_s3 <= (D_W+9)'(255) * (D_W+9)'(SPAN6 - d_c);
					end
				end
				ssag_pkg::SHAPE_CIRCLE, ssag_pkg::SHAPE_RING: begin
					if ((sh_c == ssag_pkg::SHAPE_CIRCLE || d_c >= R26)) begin
						if (diff_c < SPAN25) begin
							mode_s3 <= M_OUT;
							num_s3 <= (D_W+9)'(220) * (D_W+9)'(SPAN25 - diff_c);
						end
					end else if (d_c >= R6) begin
						mode_s3 <= M_RING;
						e2_s3 <= (2*D_W)'(d_c - R6) * (2*D_W)'(d_c - R6);
					end
				end
				ssag_pkg::SHAPE_SPHERE: begin
					if (d_c <= R32) begin
						mode_s3 <= M_SPH;
						num_s3 <= (D_W+9)'(255) * (D_W+9)'(R32 - d_c);
					end
				end
				default: ;
			endcase
		end
	end

	// shade stage 2: divide by constants
	logic [ssag_pkg::ALPHA_W-1:0] a_s4;
	logic [2*D_W+7:0] rn_c;
	logic [9:0] x3_c;
	logic [10:0] x5_c;
	logic [12:0] x25_c;
	logic [25:0] p3_c;
	logic [26:0] p5_c;
	logic [25:0] p25_c;
	always_comb begin
		rn_c = (2*D_W+8)'(e2_s3) * (2*D_W+8)'(220);
		x3_c = 10'(num_s3 >> (FRAC_BITS + 1));
		x5_c = 11'(num_s3 >> (FRAC_BITS - 1));
		x25_c = 13'(rn_c >> (2 * FRAC_BITS + 4));
		p3_c = 26'(x3_c) * 26'(DIV3_M);
		p5_c = 27'(x5_c) * 27'(DIV5_M);
		p25_c = 26'(x25_c) * 26'(DIV25_M);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			case (mode_s3)
				M_EDGE: a_s4 <= 8'(num_s3 >> (FRAC_BITS + 1));
				M_SPH: a_s4 <= 8'(num_s3 >> (FRAC_BITS + 5));
				M_OUT: a_s4 <= 8'(p5_c >> 16);
				M_LINE: a_s4 <= 8'(p3_c >> 16);
				M_RING: a_s4 <= 8'(p25_c >> 17);
				default: a_s4 <= sat_s3 ? 8'd255 : 8'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], pix.valid};
			out_vld_q <= vld_q[LAT-1];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) out_q <= a_s4;
	end

	assign alp.valid = out_vld_q;
	assign alp.alpha = out_q;
endmodule
`default_nettype wire

// File: hdl/ssag_sqrt_cell.sv
// Square root cell: one restoring result bit per cell, registered
`default_nettype none
module ssag_sqrt_cell #(
	parameter int RW = 32,
	parameter int SHIFT = 0,
	parameter int TW = 16
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [RW-1:0] rem_i,
	input  wire logic [RW-1:0] root_i,
	input  wire logic [TW-1:0] tag_i,
	output logic      [RW-1:0] rem_o,
	output logic      [RW-1:0] root_o,
	output logic      [TW-1:0] tag_o
);
	logic [RW-1:0] bit_c;
	logic [RW-1:0] trial_c;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] root_q;
	logic [TW-1:0] tag_q;

	assign bit_c = RW'(1) << SHIFT;
	assign trial_c = root_i + bit_c;

	always_ff @(posedge clk) begin
		if (en) begin
			if (rem_i >= trial_c) begin
				rem_q <= rem_i - trial_c;
				root_q <= (root_i >> 1) + bit_c;
			end else begin
				rem_q <= rem_i;
				root_q <= root_i >> 1;
			end
			tag_q <= tag_i;
		end
	end

	assign rem_o = rem_q;
	assign root_o = root_q;
	assign tag_o = tag_q;
endmodule
`default_nettype wire

// File: hdl/ssag_sqrt_chain.sv
// Square root chain: row of cells giving a floored root
`default_nettype none
module ssag_sqrt_chain #(
	parameter int RW = 32,
	parameter int TW = 16
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [RW-1:0] val_i,
	input  wire logic [TW-1:0] tag_i,
	output logic      [RW-1:0] root_o,
	output logic      [TW-1:0] tag_o
);
	localparam int N = RW / 2;
	logic [RW-1:0] rem_w [N+1];
	logic [RW-1:0] root_w [N+1];
	logic [TW-1:0] tag_w [N+1];

	assign rem_w[0] = val_i;
	assign root_w[0] = '0;
	assign tag_w[0] = tag_i;

	for (genvar k = 0; k < N; k++) begin : g_cell
		ssag_sqrt_cell #(.RW(RW), .SHIFT(RW - 2 - 2*k), .TW(TW)) u_cell (
			.clk(clk), .en(en),
			.rem_i(rem_w[k]), .root_i(root_w[k]), .tag_i(tag_w[k]),
			.rem_o(rem_w[k+1]), .root_o(root_w[k+1]), .tag_o(tag_w[k+1])
		);
	end

	assign root_o = root_w[N];
	assign tag_o = tag_w[N];
endmodule
`default_nettype wire

// File: hdl/ssag_checker.sv
// Checker: port-level properties of the sprite alpha generator, bound to the top
`default_nettype none
`include "soft_shape_alpha_generator_top_defines.svh"
module ssag_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [7:0] alpha,
	input wire logic pready
);
	`SSAG_ASSERT_NOW(a_pready, clk, arst_n, 1'b1, pready, "pready low")
	`SSAG_ASSERT_NOW(a_ready_free, clk, arst_n, !out_valid, in_ready, "stall with empty output")
	`SSAG_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(alpha), "output dropped")
endmodule

bind soft_shape_alpha_generator_top ssag_checker u_ssag_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(pix.valid), .in_ready(pix.ready),
	.out_valid(alp.valid), .out_ready(alp.ready), .alpha(alp.alpha), .pready(pready)
);
`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench for the sprite alpha generator: randomized pixel stream checked against a shape predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	localparam int GAP_MAX = 8;
	localparam int SETTLE_CYCLES = 30;
	localparam int STALL_LIMIT = 4000;
	localparam longint unsigned ONE_FX = 64'd1 << ssag_pkg::FRAC_BITS;

	typedef struct packed {
		logic [ssag_pkg::COORD_W-1:0] col;
		logic [ssag_pkg::COORD_W-1:0] row;
	} pixel_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	ssag_pix_if pix_ch ();
	ssag_alpha_if alp_ch ();

	soft_shape_alpha_generator_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_ch.sink),
		.alp(alp_ch.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	pixel_t pixel_queue[$];
	logic [ssag_pkg::ALPHA_W-1:0] alpha_expected[$];
	logic [ssag_pkg::SHAPE_W-1:0] shape_model;
	int error_count;
	int quiet_cycles;
	logic pix_fire;
	logic alp_fire;
	int send_gap;
	int take_stall;
	logic send_burst;
	logic take_burst;
	int send_count;
	int take_count;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	task automatic report(input string msg);
		$display("MISMATCH: %s", msg);
		error_count++;
	endtask

	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		longint unsigned x;
		r = 0;
		x = v;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned root_fx(input longint unsigned sq);
		return floor_root(sq << (2 * ssag_pkg::FRAC_BITS - 2));
	endfunction

	function automatic longint unsigned offset_half(input logic [ssag_pkg::COORD_W-1:0] c);
		int v;
		v = 2 * int'(c) - (ssag_pkg::SPRITE_SIZE - 3);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint unsigned edge_ramp(input longint unsigned d);
		longint unsigned outer;
		outer = 29 * ONE_FX;
		if (d < 27 * ONE_FX)
			return 255;
		if (d <= outer)
			return 255 * (outer - d) / (2 * ONE_FX);
		return 0;
	endfunction

	function automatic longint unsigned outline_ramp(input longint unsigned diff);
		longint unsigned span;
		span = 5 * ONE_FX / 2;
		if (diff >= span)
			return 0;
		return 220 * (span - diff) / span;
	endfunction

	function automatic logic [ssag_pkg::ALPHA_W-1:0] shade_pixel(
			input logic [ssag_pkg::SHAPE_W-1:0] shape, input pixel_t p);
		longint unsigned ax;
		longint unsigned ay;
		longint unsigned d;
		longint unsigned a;
		longint unsigned my;
		longint unsigned m;
		longint unsigned xr;
		longint unsigned yr;
		longint unsigned r;
		longint unsigned e;
		ax = offset_half(p.col);
		ay = offset_half(p.row);
		d = root_fx(ax * ax + ay * ay);
		a = 0;
		case (shape)
			ssag_pkg::SHAPE_DISK: a = edge_ramp(d);
			ssag_pkg::SHAPE_SQUARE:
				a = edge_ramp(((ax > ay) ? ax : ay) << (ssag_pkg::FRAC_BITS - 1));
			ssag_pkg::SHAPE_LINE: begin
				my = 6 * ay;
				m = (ax > my) ? ax : my;
				if (m < 44)
					a = 255;
				else if (m > 56)
					a = 0;
				else begin
					xr = (ax > 44) ? ax - 44 : 0;
					yr = (my > 44) ? my - 44 : 0;
					r = root_fx(xr * xr + yr * yr);
					a = (r > 6 * ONE_FX) ? 0 : 255 * (6 * ONE_FX - r) / (6 * ONE_FX);
				end
			end
			ssag_pkg::SHAPE_CIRCLE:
				a = outline_ramp((d >= 26 * ONE_FX) ? d - 26 * ONE_FX : 26 * ONE_FX - d);
			ssag_pkg::SHAPE_RING: begin
				if (d >= 26 * ONE_FX)
					a = outline_ramp(d - 26 * ONE_FX);
				else if (d >= 6 * ONE_FX) begin
					e = d - 6 * ONE_FX;
					a = 220 * e * e / (400 * ONE_FX * ONE_FX);
				end
			end
			ssag_pkg::SHAPE_SPHERE: begin
				if (d <= 32 * ONE_FX)
					a = 255 * (32 * ONE_FX - d) / (32 * ONE_FX);
			end
			default: a = 0;
		endcase
		return a[ssag_pkg::ALPHA_W-1:0];
	endfunction

	function automatic int draw_gap(input logic burst);
		return burst ? 0 : int'($urandom_range(0, GAP_MAX));
	endfunction

	// pixel driver
	always @(negedge clk) begin
		if (!arst_n) begin
			pix_ch.valid = 1'b0;
		end else if (pix_ch.valid && !pix_fire) begin
		end else if (send_gap > 0) begin
			pix_ch.valid = 1'b0;
			send_gap--;
		end else if (pixel_queue.size() > 0) begin
			{pix_ch.pixel_col, pix_ch.pixel_row} = pixel_queue.pop_front();
			pix_ch.valid = 1'b1;
			send_count++;
			if (send_count % 50 == 0)
				send_burst = ($urandom_range(0, 2) == 0);
			send_gap = draw_gap(send_burst);
		end else begin
			pix_ch.valid = 1'b0;
		end
	end

	// alpha sink stall
	always @(negedge clk) begin
		if (!arst_n) begin
			alp_ch.ready = 1'b0;
		end else begin
			if (alp_fire) begin
				take_count++;
				if (take_count % 60 == 0)
					take_burst = ($urandom_range(0, 2) == 0);
				take_stall = draw_gap(take_burst);
			end
			if (take_stall > 0) begin
				alp_ch.ready = 1'b0;
				take_stall--;
			end else begin
				alp_ch.ready = 1'b1;
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		logic [ssag_pkg::ALPHA_W-1:0] want;
		pix_fire <= pix_ch.valid && pix_ch.ready;
		alp_fire <= alp_ch.valid && alp_ch.ready;
		if (arst_n && pix_ch.valid && pix_ch.ready)
			alpha_expected.push_back(shade_pixel(shape_model,
				{pix_ch.pixel_col, pix_ch.pixel_row}));
		if (arst_n && alp_ch.valid && alp_ch.ready) begin
			if (alpha_expected.size() == 0) begin
				report($sformatf("unexpected alpha %0d", alp_ch.alpha));
			end else begin
				want = alpha_expected.pop_front();
				if (alp_ch.alpha !== want)
					report($sformatf("alpha %0d, expected %0d", alp_ch.alpha, want));
			end
		end
		if ((pix_ch.valid && pix_ch.ready) || (alp_ch.valid && alp_ch.ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_shape(input logic [ssag_pkg::SHAPE_W-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = 2'(ssag_pkg::REG_SHAPE);
		pwdata = 32'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		shape_model = value;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic add_pixel(input int c, input int r);
		pixel_queue.push_back({6'(c), 6'(r)});
	endtask

	task automatic drain();
		while (pixel_queue.size() > 0 || alpha_expected.size() > 0 || pix_ch.valid)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	logic [ssag_pkg::SHAPE_W-1:0] phase_shapes[9] = '{ssag_pkg::SHAPE_SPHERE,
		ssag_pkg::SHAPE_DISK, ssag_pkg::SHAPE_SQUARE, ssag_pkg::SHAPE_LINE,
		ssag_pkg::SHAPE_CIRCLE, ssag_pkg::SHAPE_RING, 3'd6, 3'd7, ssag_pkg::SHAPE_SPHERE};

	initial begin
		int k;
		int v;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel_col = '0;
		pix_ch.pixel_row = '0;
		alp_ch.ready = 1'b0;
		shape_model = ssag_pkg::SHAPE_DISK;
		error_count = 0;
		quiet_cycles = 0;
		pix_fire = 1'b0;
		alp_fire = 1'b0;
		send_gap = 0;
		take_stall = 0;
		send_burst = 1'b0;
		take_burst = 1'b0;
		send_count = 0;
		take_count = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// reset shape first
		for (k = 0; k < 12; k++)
			add_pixel($urandom_range(0, 63), $urandom_range(0, 63));
		drain();
		foreach (phase_shapes[p]) begin
			write_shape(phase_shapes[p]);
			add_pixel(0, 0);
			add_pixel(63, 63);
			add_pixel(0, 63);
			add_pixel(63, 0);
			add_pixel(30, 30);
			add_pixel(31, 31);
			add_pixel(2, 31);
			add_pixel(58, 31);
			add_pixel(31, 3);
			add_pixel(31, 57);
			add_pixel(42, 42);
			add_pixel(33, 31);
			for (k = 0; k < 85; k++) begin
				v = $urandom_range(0, 3);
				if (v == 0)
					add_pixel($urandom_range(0, 63), 30 + $urandom_range(0, 2));
				else
					add_pixel($urandom_range(0, 63), $urandom_range(0, 63));
			end
			drain();
		end
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// File: files.f
+incdir+hdl
hdl/ssag_pkg.sv
hdl/ssag_if.sv
hdl/ssag_sqrt_cell.sv
hdl/ssag_sqrt_chain.sv
hdl/soft_shape_alpha_generator_top.sv
hdl/ssag_checker.sv
tb/sv/tb_top.sv
